/* hdl/tcmc_pkg.sv */
package tcmc_pkg;

    localparam int MEM_WORDS_DEF = 512;
    localparam int WORD_BITS_DEF = 32;

    localparam int IDX_W   = 9;
    localparam int LINE_W  = 8;
    localparam int OUT_W   = 32;
    localparam int STATE_W = 2;
    localparam int BUS_W   = 3;

    typedef enum logic [STATE_W-1:0] {
        COH_I = 2'd0,
        COH_S = 2'd1,
        COH_M = 2'd2
    } coh_state_t;

    typedef enum logic [BUS_W-1:0] {
        BUS_NONE    = 3'd0,
        BUS_READ    = 3'd1,
        BUS_RIM     = 3'd2,
        BUS_INV     = 3'd3,
        BUS_READ_WB = 3'd4,
        BUS_RIM_WB  = 3'd5
    } bus_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_FETCH_ODD,
        FSM_COMMIT
    } fsm_t;

    // The word index is narrow, so the remainder is found by a short chain of
    // conditional subtractions of shifted copies of the memory size.
    function automatic logic [IDX_W-1:0] word_mod(input logic [IDX_W-1:0] x,
                                                  input int unsigned m);
        int unsigned r;
        r = 32'(x);
        for (int k = IDX_W - 1; k >= 0; k--)
        begin
            if (r >= (m << k))
            begin
                r = r - (m << k);
            end
        end
        return IDX_W'(r);
    endfunction

endpackage

/* hdl/tcmc_if.sv */
interface tcmc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic                      cpu_id;
    logic [tcmc_pkg::IDX_W-1:0] word_index;

    modport source (output valid, output req_type, output cpu_id, output word_index,
                    input ready);
    modport sink (input valid, input req_type, input cpu_id, input word_index,
                  output ready);
endinterface

interface tcmc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [tcmc_pkg::BUS_W-1:0]   bus_action;
    logic                        victim_writeback;
    logic [tcmc_pkg::STATE_W-1:0] cpu0_state;
    logic [tcmc_pkg::LINE_W-1:0]  cpu0_line;
    logic [tcmc_pkg::OUT_W-1:0]   cpu0_word_even;
    logic [tcmc_pkg::OUT_W-1:0]   cpu0_word_odd;
    logic [tcmc_pkg::STATE_W-1:0] cpu1_state;
    logic [tcmc_pkg::LINE_W-1:0]  cpu1_line;
    logic [tcmc_pkg::OUT_W-1:0]   cpu1_word_even;
    logic [tcmc_pkg::OUT_W-1:0]   cpu1_word_odd;

    modport source (output valid, output hit, output bus_action, output victim_writeback,
                    output cpu0_state, output cpu0_line, output cpu0_word_even,
                    output cpu0_word_odd, output cpu1_state, output cpu1_line,
                    output cpu1_word_even, output cpu1_word_odd, input ready);
    modport sink (input valid, input hit, input bus_action, input victim_writeback,
                  input cpu0_state, input cpu0_line, input cpu0_word_even,
                  input cpu0_word_odd, input cpu1_state, input cpu1_line,
                  input cpu1_word_even, input cpu1_word_odd, output ready);
endinterface

/* hdl/tcmc_ram.sv */
module tcmc_ram #(
    parameter int DEPTH = tcmc_pkg::MEM_WORDS_DEF,
    parameter int WIDTH = tcmc_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hdl/two_core_msi_coherence_core.sv */
// Two-processor MSI snooping coherence engine over a shared word memory.
// The req channel carries one access transaction: read or write (a write adds
// one to the word), the requesting processor and the word index. For every
// request the rsp channel returns one transaction with hit, the bus action,
// the victim writeback flag and the state, line and both words of each cache.
// A hit goes from the idle state that accepts it straight to the commit state,
// which writes the response register; a miss first passes the fetch-odd
// state, the second read of the line from the single-port main memory, which
// delivers one word per cycle. Requests are taken one at a time; the next
// request is accepted as soon as the previous one has been written to the
// response register, even while that response still waits for the receiver.
// After reset all MEM_WORDS words of the memory are cleared, one word per
// cycle, with ready held low; both caches start invalid.
// When the receiver stalls, a finished request waits in the commit state until
// the response register is free, and then completes.
module two_core_msi_coherence_core #(
    parameter int MEM_WORDS = tcmc_pkg::MEM_WORDS_DEF,
    parameter int WORD_BITS = tcmc_pkg::WORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tcmc_req_if.sink     req,
    tcmc_rsp_if.source   rsp
);

    localparam int AW = $clog2(MEM_WORDS);

    tcmc_pkg::fsm_t state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg;

    logic                       req_type_reg;
    logic                       cpu_reg;
    logic [tcmc_pkg::IDX_W-1:0] w_reg;
    logic                       hit_reg;
    logic [WORD_BITS-1:0]       even_fetch_reg;

    tcmc_pkg::coh_state_t        st_reg  [2];
    logic [tcmc_pkg::LINE_W-1:0] line_reg[2];
    logic [WORD_BITS-1:0]        wd_reg  [4];

    tcmc_pkg::coh_state_t        st_nx  [2];
    logic [tcmc_pkg::LINE_W-1:0] line_nx[2];
    logic [WORD_BITS-1:0]        wd_nx  [4];

    logic                         out_valid_reg;
    logic                         o_hit_reg;
    logic [tcmc_pkg::BUS_W-1:0]   o_bus_reg;
    logic                         o_vwb_reg;
    logic [tcmc_pkg::STATE_W-1:0] o_st_reg  [2];
    logic [tcmc_pkg::LINE_W-1:0]  o_line_reg[2];
    logic [tcmc_pkg::OUT_W-1:0]   o_we_reg  [2];
    logic [tcmc_pkg::OUT_W-1:0]   o_wo_reg  [2];

    logic [tcmc_pkg::IDX_W-1:0]  w_in;
    logic [tcmc_pkg::LINE_W-1:0] line_in;
    logic                        hit_in;
    logic [AW-1:0]               ea_in;
    logic [AW-1:0]               ea_r;
    logic [AW-1:0]               oa_r;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                        commit;
    logic                        accept;
    logic                        c_idx;
    logic                        o_idx;
    logic [tcmc_pkg::LINE_W-1:0] line_c;
    logic [WORD_BITS-1:0]        fe;
    logic [WORD_BITS-1:0]        fo;
    logic [WORD_BITS-1:0]        ne;
    logic [WORD_BITS-1:0]        no;
    logic [WORD_BITS-1:0]        mem_wdata;
    tcmc_pkg::bus_t              bus;
    logic                        vwb;

    function automatic logic [tcmc_pkg::OUT_W-1:0] to_out(input logic [WORD_BITS-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[tcmc_pkg::OUT_W-1:0];
    endfunction

    tcmc_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign w_in    = tcmc_pkg::word_mod(req.word_index, MEM_WORDS);
    assign line_in = w_in[tcmc_pkg::IDX_W-1:1];
    assign hit_in  = (st_reg[req.cpu_id] != tcmc_pkg::COH_I) &&
                     (line_reg[req.cpu_id] == line_in);
    assign ea_in   = AW'({line_in, 1'b0});
    assign ea_r    = AW'({w_reg[tcmc_pkg::IDX_W-1:1], 1'b0});
    assign oa_r    = (ea_r == AW'(MEM_WORDS - 1)) ? '0 : ea_r + 1'b1;
    assign accept  = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcmc_pkg::FSM_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = tcmc_pkg::FSM_IDLE;
                end
            end
            tcmc_pkg::FSM_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = hit_in ? tcmc_pkg::FSM_COMMIT : tcmc_pkg::FSM_FETCH_ODD;
                end
            end
            tcmc_pkg::FSM_FETCH_ODD:
            begin
                state_next = tcmc_pkg::FSM_COMMIT;
            end
            tcmc_pkg::FSM_COMMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = tcmc_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = tcmc_pkg::FSM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = ea_in;
        ram_wdata = mem_wdata;
        commit    = 1'b0;
        case (state_reg)
            tcmc_pkg::FSM_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            tcmc_pkg::FSM_IDLE:
            begin
                req.ready = 1'b1;
                ram_re    = req.valid;
                ram_addr  = ea_in;
            end
            tcmc_pkg::FSM_FETCH_ODD:
            begin
                ram_re   = 1'b1;
                ram_addr = oa_r;
            end
            tcmc_pkg::FSM_COMMIT:
            begin
                commit   = !out_valid_reg || rsp.ready;
                ram_we   = commit && req_type_reg;
                ram_addr = AW'(w_reg);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign c_idx  = cpu_reg;
    assign o_idx  = ~cpu_reg;
    assign line_c = w_reg[tcmc_pkg::IDX_W-1:1];
    assign fe     = hit_reg ? wd_reg[{c_idx, 1'b0}] : even_fetch_reg;
    assign fo     = hit_reg ? wd_reg[{c_idx, 1'b1}] : ram_rdata;
    assign ne     = (req_type_reg && !w_reg[0]) ? fe + 1'b1 : fe;
    assign no     = (req_type_reg && w_reg[0]) ? fo + 1'b1 : fo;
    assign mem_wdata = w_reg[0] ? no : ne;

    always_comb
    begin
        st_nx   = st_reg;
        line_nx = line_reg;
        wd_nx   = wd_reg;
        bus     = tcmc_pkg::BUS_NONE;
        vwb     = 1'b0;
        if (!hit_reg)
        begin
            vwb            = (st_reg[c_idx] == tcmc_pkg::COH_M);
            line_nx[c_idx] = line_c;
        end
        wd_nx[{c_idx, 1'b0}] = ne;
        wd_nx[{c_idx, 1'b1}] = no;
        if (!req_type_reg)
        begin
            if (!hit_reg)
            begin
                st_nx[c_idx] = tcmc_pkg::COH_S;
                bus          = tcmc_pkg::BUS_READ;
            end
        end
        else
        begin
            if (!hit_reg)
            begin
                bus = tcmc_pkg::BUS_RIM;
            end
            else if (st_reg[c_idx] == tcmc_pkg::COH_S)
            begin
                bus = tcmc_pkg::BUS_INV;
            end
            st_nx[c_idx] = tcmc_pkg::COH_M;
        end
        if ((st_reg[o_idx] != tcmc_pkg::COH_I) && (line_reg[o_idx] == line_c))
        begin
            if (st_reg[o_idx] == tcmc_pkg::COH_S)
            begin
                if ((bus == tcmc_pkg::BUS_RIM) || (bus == tcmc_pkg::BUS_INV))
                begin
                    st_nx[o_idx] = tcmc_pkg::COH_I;
                end
            end
            else if (st_reg[o_idx] == tcmc_pkg::COH_M)
            begin
                if (bus == tcmc_pkg::BUS_READ)
                begin
                    st_nx[o_idx] = tcmc_pkg::COH_S;
                    bus          = tcmc_pkg::BUS_READ_WB;
                end
                else if (bus == tcmc_pkg::BUS_RIM)
                begin
                    st_nx[o_idx] = tcmc_pkg::COH_I;
                    bus          = tcmc_pkg::BUS_RIM_WB;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcmc_pkg::FSM_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            st_reg[0]     <= tcmc_pkg::COH_I;
            st_reg[1]     <= tcmc_pkg::COH_I;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tcmc_pkg::FSM_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_nx;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            cpu_reg      <= req.cpu_id;
            w_reg        <= w_in;
            hit_reg      <= hit_in;
        end
        if (state_reg == tcmc_pkg::FSM_FETCH_ODD)
        begin
            even_fetch_reg <= ram_rdata;
        end
        if (commit)
        begin
            line_reg  <= line_nx;
            wd_reg    <= wd_nx;
            o_hit_reg <= hit_reg;
            o_bus_reg <= bus;
            o_vwb_reg <= vwb;
            for (int i = 0; i < 2; i++)
            begin
                if (st_nx[i] == tcmc_pkg::COH_I)
                begin
                    o_st_reg[i]   <= tcmc_pkg::COH_I;
                    o_line_reg[i] <= '0;
                    o_we_reg[i]   <= '0;
                    o_wo_reg[i]   <= '0;
                end
                else
                begin
                    o_st_reg[i]   <= st_nx[i];
                    o_line_reg[i] <= line_nx[i];
                    o_we_reg[i]   <= to_out(wd_nx[2 * i]);
                    o_wo_reg[i]   <= to_out(wd_nx[2 * i + 1]);
                end
            end
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.hit              = o_hit_reg;
    assign rsp.bus_action       = o_bus_reg;
    assign rsp.victim_writeback = o_vwb_reg;
    assign rsp.cpu0_state       = o_st_reg[0];
    assign rsp.cpu0_line        = o_line_reg[0];
    assign rsp.cpu0_word_even   = o_we_reg[0];
    assign rsp.cpu0_word_odd    = o_wo_reg[0];
    assign rsp.cpu1_state       = o_st_reg[1];
    assign rsp.cpu1_line        = o_line_reg[1];
    assign rsp.cpu1_word_even   = o_we_reg[1];
    assign rsp.cpu1_word_odd    = o_wo_reg[1];

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcmc_pkg::FSM_CLEAR) |-> !req.ready)
        else $error("request accepted during memory clear");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg[0] == tcmc_pkg::COH_M && st_reg[1] != tcmc_pkg::COH_I) ||
         (st_reg[1] == tcmc_pkg::COH_M && st_reg[0] != tcmc_pkg::COH_I))
        |-> (line_reg[0] != line_reg[1]))
        else $error("modified line also valid in the other cache");

    a_hit_skips_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit_in) |=> (state_reg == tcmc_pkg::FSM_COMMIT))
        else $error("hit did not go straight to commit");

    a_miss_only_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.victim_writeback ||
                       rsp.bus_action == tcmc_pkg::BUS_READ ||
                       rsp.bus_action == tcmc_pkg::BUS_RIM ||
                       rsp.bus_action == tcmc_pkg::BUS_READ_WB ||
                       rsp.bus_action == tcmc_pkg::BUS_RIM_WB)) |-> !rsp.hit)
        else $error("miss-only response flag on a hit");

endmodule

/* tb/tcmc_coherence_checker.sv */
`timescale 1ns / 100ps

module tcmc_coherence_checker
    import tcmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tcmc_req_if  access_mon,
    tcmc_rsp_if  snapshot_mon,
    output int   mismatch_count,
    output int   pending_count,
    output int   checked_count
);

    localparam int MEM_SIZE = MEM_WORDS_DEF;

    typedef struct {
        logic                 hit;
        bus_t                 bus;
        logic                 evict_wb;
        coh_state_t           state[2];
        logic [LINE_W-1:0]    line[2];
        logic [OUT_W-1:0]     word_even[2];
        logic [OUT_W-1:0]     word_odd[2];
    } snapshot_t;

    coh_state_t           cache_state[2];
    logic [LINE_W-1:0]    cache_line[2];
    logic [OUT_W-1:0]     cache_word[2][2];
    logic [OUT_W-1:0]     shared_mem[MEM_SIZE];
    snapshot_t            expected_snapshots[$];

    int mismatches = 0;
    int checked = 0;
    int pending = 0;

    assign mismatch_count = mismatches;
    assign pending_count  = pending;
    assign checked_count  = checked;

    function automatic snapshot_t apply_access(input logic is_write, input logic cpu,
                                               input logic [IDX_W-1:0] word);
        snapshot_t   snap;
        int unsigned addr;
        int unsigned line;
        int unsigned odd;
        int unsigned even_addr;
        int unsigned odd_addr;
        logic        peer;
        logic        hit;
        logic        evict_wb;
        bus_t        bus;
        peer      = ~cpu;
        addr      = int'(word) % MEM_SIZE;
        line      = addr / 2;
        odd       = addr % 2;
        even_addr = line * 2;
        odd_addr  = (even_addr + 1) % MEM_SIZE;
        hit       = (cache_state[cpu] != COH_I) && (cache_line[cpu] == LINE_W'(line));
        evict_wb  = 1'b0;
        bus       = BUS_NONE;

        if (!hit)
        begin
            evict_wb             = (cache_state[cpu] == COH_M);
            cache_line[cpu]      = LINE_W'(line);
            cache_word[cpu][0]   = shared_mem[even_addr];
            cache_word[cpu][1]   = shared_mem[odd_addr];
        end

        if (!is_write)
        begin
            if (!hit)
            begin
                cache_state[cpu] = COH_S;
                bus              = BUS_READ;
            end
        end
        else
        begin
            cache_word[cpu][odd] = cache_word[cpu][odd] + 1'b1;
            shared_mem[addr]     = shared_mem[addr] + 1'b1;
            if (!hit)
            begin
                bus = BUS_RIM;
            end
            else if (cache_state[cpu] == COH_S)
            begin
                bus = BUS_INV;
            end
            cache_state[cpu] = COH_M;
        end

        if (cache_state[peer] != COH_I && cache_line[peer] == LINE_W'(line))
        begin
            if (cache_state[peer] == COH_S)
            begin
                if (bus == BUS_RIM || bus == BUS_INV)
                begin
                    cache_state[peer] = COH_I;
                end
            end
            else if (cache_state[peer] == COH_M)
            begin
                if (bus == BUS_READ)
                begin
                    cache_state[peer] = COH_S;
                    bus               = BUS_READ_WB;
                end
                else if (bus == BUS_RIM)
                begin
                    cache_state[peer] = COH_I;
                    bus               = BUS_RIM_WB;
                end
            end
        end

        snap.hit      = hit;
        snap.bus      = bus;
        snap.evict_wb = evict_wb;
        for (int c = 0; c < 2; c++)
        begin
            snap.state[c] = cache_state[c];
            if (cache_state[c] == COH_I)
            begin
                snap.line[c]      = '0;
                snap.word_even[c] = '0;
                snap.word_odd[c]  = '0;
            end
            else
            begin
                snap.line[c]      = cache_line[c];
                snap.word_even[c] = cache_word[c][0];
                snap.word_odd[c]  = cache_word[c][1];
            end
        end
        return snap;
    endfunction

    function automatic void check_field(input string label, input logic [OUT_W-1:0] exp_value,
                                        input logic [OUT_W-1:0] act_value);
        if (exp_value !== act_value)
        begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h",
                     $time, label, exp_value, act_value);
            mismatches++;
        end
    endfunction

    task automatic compare_snapshot();
        snapshot_t exp_snap;
        if (expected_snapshots.size() == 0)
        begin
            $display("%0t: response transaction arrived with no request outstanding", $time);
            mismatches++;
            return;
        end
        exp_snap = expected_snapshots.pop_front();
        checked++;
        check_field("hit", OUT_W'(exp_snap.hit), OUT_W'(snapshot_mon.hit));
        check_field("bus_action", OUT_W'(exp_snap.bus), OUT_W'(snapshot_mon.bus_action));
        check_field("victim_writeback", OUT_W'(exp_snap.evict_wb),
                    OUT_W'(snapshot_mon.victim_writeback));
        check_field("cpu0_state", OUT_W'(exp_snap.state[0]), OUT_W'(snapshot_mon.cpu0_state));
        check_field("cpu0_line", OUT_W'(exp_snap.line[0]), OUT_W'(snapshot_mon.cpu0_line));
        check_field("cpu0_word_even", exp_snap.word_even[0], snapshot_mon.cpu0_word_even);
        check_field("cpu0_word_odd", exp_snap.word_odd[0], snapshot_mon.cpu0_word_odd);
        check_field("cpu1_state", OUT_W'(exp_snap.state[1]), OUT_W'(snapshot_mon.cpu1_state));
        check_field("cpu1_line", OUT_W'(exp_snap.line[1]), OUT_W'(snapshot_mon.cpu1_line));
        check_field("cpu1_word_even", exp_snap.word_even[1], snapshot_mon.cpu1_word_even);
        check_field("cpu1_word_odd", exp_snap.word_odd[1], snapshot_mon.cpu1_word_odd);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                cache_state[c]   = COH_I;
                cache_line[c]    = '0;
                cache_word[c][0] = '0;
                cache_word[c][1] = '0;
            end
            foreach (shared_mem[a])
            begin
                shared_mem[a] = '0;
            end
            expected_snapshots.delete();
            pending = 0;
        end
        else
        begin
            if (snapshot_mon.valid && snapshot_mon.ready)
            begin
                compare_snapshot();
            end
            if (access_mon.valid && access_mon.ready)
            begin
                expected_snapshots.push_back(apply_access(access_mon.req_type,
                                                          access_mon.cpu_id,
                                                          access_mon.word_index));
            end
            pending = expected_snapshots.size();
        end
    end

endmodule

/* tb/tb_two_core_msi_coherence_core.sv */
`timescale 1ns / 100ps

module tb_two_core_msi_coherence_core;

    import tcmc_pkg::*;

    localparam logic OP_READ      = 1'b0;
    localparam logic OP_WRITE     = 1'b1;
    localparam int   PHASE_ITEMS  = 165;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   DRAIN_LIMIT  = 20000;

    logic clk;
    logic rst_n;

    int   idle_pct;
    int   stall_pct;
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;
    int   sent_count;
    int   mismatch_count;
    int   pending_count;
    int   checked_count;

    logic [LINE_W-1:0] line_pool[4];

    tcmc_req_if access_ch();
    tcmc_rsp_if snapshot_ch();

    two_core_msi_coherence_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (access_ch),
        .rsp   (snapshot_ch)
    );

    tcmc_coherence_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .access_mon     (access_ch),
        .snapshot_mon   (snapshot_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The response side stalls at random and runs a long hold-off on request.
    initial
    begin
        snapshot_ch.ready = 1'b0;
        hold_seen         = 1'b0;
        hold_left         = 0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                snapshot_ch.ready <= 1'b0;
            end
            else
            begin
                snapshot_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic issue_access(input logic op, input logic cpu, input logic [IDX_W-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid      <= 1'b1;
        access_ch.req_type   <= op;
        access_ch.cpu_id     <= cpu;
        access_ch.word_index <= word;
        sent_count++;
        do
        begin
            @(posedge clk);
        end
        while (!access_ch.ready);
    endtask

    task automatic wait_drained();
        access_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
    endtask

    task automatic random_traffic(input int count, input int hold_at);
        logic [IDX_W-1:0] word;
        foreach (line_pool[k])
        begin
            line_pool[k] = LINE_W'($urandom_range(255));
        end
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
            begin
                hold_toggle = ~hold_toggle;
            end
            if ($urandom_range(99) < 75)
            begin
                word = {line_pool[$urandom_range(3)], 1'($urandom_range(1))};
            end
            else
            begin
                word = IDX_W'($urandom_range(511));
            end
            issue_access(1'($urandom_range(1)), 1'($urandom_range(1)), word);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        hold_toggle          = 1'b0;
        sent_count           = 0;
        access_ch.valid      = 1'b0;
        access_ch.req_type   = OP_READ;
        access_ch.cpu_id     = 1'b0;
        access_ch.word_index = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the protocol through every requester transition and snoop reaction.
        issue_access(OP_READ,  1'b0, 9'd0);
        issue_access(OP_READ,  1'b0, 9'd1);
        issue_access(OP_READ,  1'b1, 9'd0);
        issue_access(OP_WRITE, 1'b0, 9'd1);
        issue_access(OP_WRITE, 1'b0, 9'd1);
        issue_access(OP_READ,  1'b1, 9'd0);
        issue_access(OP_WRITE, 1'b1, 9'd0);
        issue_access(OP_WRITE, 1'b0, 9'd0);
        issue_access(OP_WRITE, 1'b0, 9'd511);
        issue_access(OP_READ,  1'b1, 9'd510);
        issue_access(OP_WRITE, 1'b1, 9'd2);
        issue_access(OP_READ,  1'b0, 9'd3);
        issue_access(OP_WRITE, 1'b1, 9'd511);
        issue_access(OP_WRITE, 1'b0, 9'd510);
        issue_access(OP_READ,  1'b1, 9'd511);
        issue_access(OP_WRITE, 1'b1, 9'd256);
        issue_access(OP_WRITE, 1'b1, 9'd257);
        issue_access(OP_READ,  1'b1, 9'd256);
        issue_access(OP_WRITE, 1'b0, 9'd256);
        issue_access(OP_WRITE, 1'b0, 9'd300);
        issue_access(OP_WRITE, 1'b1, 9'd300);
        issue_access(OP_READ,  1'b0, 9'd170);
        wait_drained();

        random_traffic(PHASE_ITEMS, 40);
        idle_pct  = 47;
        stall_pct = 0;
        random_traffic(PHASE_ITEMS, -1);
        wait_drained();
        idle_pct  = 0;
        stall_pct = 47;
        random_traffic(PHASE_ITEMS, -1);
        idle_pct  = 7;
        stall_pct = 7;
        random_traffic(PHASE_ITEMS, -1);
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(PHASE_ITEMS, 60);

        access_ch.valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_count != 0; k++)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Drove %0d access transactions: directed MSI transitions, shared-line random",
                 sent_count);
        $display("traffic under idle, stall and long hold-off phases; %0d responses compared.",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
